/* design/i2crm_pkg.sv */
// Package for the I2C register master: bus phase encoding, function codes,
// request and result beat types. No dependencies.
`timescale 1ns / 1ps

package i2crm_pkg;

  typedef enum logic [4:0] {
    PH_IDLE        = 5'd0,
    PH_START_REL   = 5'd1,
    PH_START_SDA   = 5'd2,
    PH_START_SCL   = 5'd3,
    PH_WBIT_SET    = 5'd4,
    PH_WBIT_HIGH   = 5'd5,
    PH_WBIT_LOW    = 5'd6,
    PH_WACK_REL    = 5'd7,
    PH_WACK_SAMPLE = 5'd8,
    PH_WACK_LOW    = 5'd9,
    PH_RBIT_REL    = 5'd10,
    PH_RBIT_SAMPLE = 5'd11,
    PH_RBIT_LOW    = 5'd12,
    PH_RACK_PREP   = 5'd13,
    PH_RACK_SET    = 5'd14,
    PH_RACK_HIGH   = 5'd15,
    PH_RACK_LOW    = 5'd16,
    PH_RACK_DONE   = 5'd17,
    PH_STOP_SDA    = 5'd18,
    PH_STOP_SCL    = 5'd19,
    PH_STOP_REL    = 5'd20
  } phase_e;

  localparam logic [1:0]  FN_READ_BYTE  = 2'd0;
  localparam logic [1:0]  FN_READ_WORD  = 2'd1;
  localparam logic [1:0]  FN_WRITE_BYTE = 2'd2;
  localparam logic [1:0]  FN_UNUSED     = 2'd3;

  localparam logic [3:0]  BYTE_BITS     = 4'd8;
  localparam logic        RW_READ       = 1'b1;
  localparam logic [15:0] HPT_RESET     = 16'd300;

  typedef struct packed {
    logic       go;
    logic [1:0] func;
    logic [6:0] device_addr;
    logic [7:0] reg_addr;
    logic [7:0] write_data;
    logic       scl_in;
    logic       sda_in;
  } req_t;

  typedef struct packed {
    logic        scl_low;
    logic        sda_low;
    logic        busy_res;
    logic        done_res;
    logic [15:0] read_data;
    logic        nak_seen;
  } result_t;

endpackage

/* design/i2crm_in_if.sv */
// Input channel of the I2C register master: valid/ready plus one tick's
// request fields and sampled bus levels. No dependencies.
`timescale 1ns / 1ps

interface i2crm_in_if;
  logic       valid;
  logic       ready;
  logic       go;
  logic [1:0] func;
  logic [6:0] device_addr;
  logic [7:0] reg_addr;
  logic [7:0] write_data;
  logic       scl_in;
  logic       sda_in;

  modport source (
    output valid, go, func, device_addr, reg_addr, write_data, scl_in, sda_in,
    input  ready
  );
  modport sink (
    input  valid, go, func, device_addr, reg_addr, write_data, scl_in, sda_in,
    output ready
  );
endinterface

/* design/i2crm_out_if.sv */
// Output channel of the I2C register master: valid/ready plus line drives
// and transaction status. No dependencies.
`timescale 1ns / 1ps

interface i2crm_out_if;
  logic        valid;
  logic        ready;
  logic        scl_low;
  logic        sda_low;
  logic        busy_res;
  logic        done_res;
  logic [15:0] read_data;
  logic        nak_seen;

  modport source (
    output valid, scl_low, sda_low, busy_res, done_res, read_data, nak_seen,
    input  ready
  );
  modport sink (
    input  valid, scl_low, sda_low, busy_res, done_res, read_data, nak_seen,
    output ready
  );
endinterface

/* design/i2crm_core.sv */
// Transaction sequencer of the I2C register master: phase register, delay
// counter, shift register and held request. Depends on i2crm_pkg.
`timescale 1ns / 1ps

module i2crm_core import i2crm_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        step_i,
  input  req_t        req_i,
  output result_t     res_o
);

  phase_e      phase_q, phase_d, enter_ph;
  logic        enter;
  logic [15:0] hpt_q, hpt_load;
  logic [15:0] delay_q, delay_d;
  logic [3:0]  bit_q, bit_d;
  logic [7:0]  shift_q, shift_d;
  logic [1:0]  byte_idx_q, byte_idx_d;
  logic [15:0] result_q, result_d;
  logic [1:0]  func_q, func_d;
  logic [6:0]  dev_q, dev_d;
  logic [7:0]  reg_q, reg_d;
  logic [7:0]  data_q, data_d;
  logic        nak_q, nak_d;
  logic        scl_q, scl_d;
  logic        sda_q, sda_d;
  logic        restart_q, restart_d;
  logic        done;

  // successor for phases that simply move on
  function automatic phase_e next_phase(input phase_e p);
    phase_e n;
    case (p)
      PH_START_REL:  n = PH_START_SDA;
      PH_START_SDA:  n = PH_START_SCL;
      PH_WBIT_SET:   n = PH_WBIT_HIGH;
      PH_WBIT_HIGH:  n = PH_WBIT_LOW;
      PH_WACK_REL:   n = PH_WACK_SAMPLE;
      PH_RBIT_REL:   n = PH_RBIT_SAMPLE;
      PH_RACK_PREP:  n = PH_RACK_SET;
      PH_RACK_SET:   n = PH_RACK_HIGH;
      PH_RACK_HIGH:  n = PH_RACK_LOW;
      PH_RACK_LOW:   n = PH_RACK_DONE;
      PH_STOP_SDA:   n = PH_STOP_SCL;
      PH_STOP_SCL:   n = PH_STOP_REL;
      default:       n = PH_IDLE;
    endcase
    return n;
  endfunction

  assign hpt_load = (hpt_q == 16'd0) ? 16'd1 : hpt_q;

  always_comb begin
    phase_d    = phase_q;
    delay_d    = delay_q;
    bit_d      = bit_q;
    shift_d    = shift_q;
    byte_idx_d = byte_idx_q;
    result_d   = result_q;
    func_d     = func_q;
    dev_d      = dev_q;
    reg_d      = reg_q;
    data_d     = data_q;
    nak_d      = nak_q;
    scl_d      = scl_q;
    sda_d      = sda_q;
    restart_d  = restart_q;
    enter      = 1'b0;
    enter_ph   = PH_IDLE;
    done       = 1'b0;

    case (phase_q)
      PH_IDLE: begin
        if (req_i.go && req_i.func != FN_UNUSED) begin
          func_d     = req_i.func;
          dev_d      = req_i.device_addr;
          reg_d      = req_i.reg_addr;
          data_d     = req_i.write_data;
          nak_d      = 1'b0;
          result_d   = '0;
          restart_d  = 1'b0;
          byte_idx_d = '0;
          enter      = 1'b1;
          enter_ph   = PH_START_REL;
        end
      end
      // SCL released: wait for the line to read high (clock stretching)
      PH_WBIT_SET, PH_WACK_REL, PH_RBIT_REL, PH_RACK_SET: begin
        if (req_i.scl_in) begin
          enter    = 1'b1;
          enter_ph = next_phase(phase_q);
        end
      end
      PH_START_REL, PH_START_SDA, PH_START_SCL, PH_WBIT_HIGH, PH_WBIT_LOW,
      PH_WACK_SAMPLE, PH_WACK_LOW, PH_RBIT_SAMPLE, PH_RBIT_LOW, PH_RACK_PREP,
      PH_RACK_HIGH, PH_RACK_LOW, PH_RACK_DONE, PH_STOP_SDA, PH_STOP_SCL,
      PH_STOP_REL: begin
        if (delay_q > 16'd1) begin
          delay_d = delay_q - 16'd1;
        end else begin
          delay_d = '0;
          enter   = 1'b1;
          case (phase_q)
            PH_START_SCL: begin
              byte_idx_d = '0;
              shift_d    = {dev_q, restart_q ? RW_READ : 1'b0};
              bit_d      = '0;
              enter_ph   = PH_WBIT_SET;
            end
            PH_WBIT_LOW: begin
              bit_d = bit_q + 4'd1;
              if (bit_d < BYTE_BITS) begin
                shift_d  = {shift_q[6:0], 1'b0};
                enter_ph = PH_WBIT_SET;
              end else begin
                enter_ph = PH_WACK_REL;
              end
            end
            PH_WACK_SAMPLE: begin
              if (req_i.sda_in) nak_d = 1'b1;
              enter_ph = PH_WACK_LOW;
            end
            PH_WACK_LOW: begin
              byte_idx_d = byte_idx_q + 2'd1;
              if (restart_q) begin
                byte_idx_d = '0;
                shift_d    = '0;
                bit_d      = '0;
                enter_ph   = PH_RBIT_REL;
              end else if (byte_idx_d == 2'd1) begin
                shift_d  = reg_q;
                bit_d    = '0;
                enter_ph = PH_WBIT_SET;
              end else if (byte_idx_d == 2'd2) begin
                if (func_q == FN_WRITE_BYTE) begin
                  shift_d  = data_q;
                  bit_d    = '0;
                  enter_ph = PH_WBIT_SET;
                end else begin
                  restart_d = 1'b1;
                  enter_ph  = PH_START_REL;
                end
              end else begin
                enter_ph = PH_STOP_SDA;
              end
            end
            PH_RBIT_SAMPLE: begin
              shift_d  = {shift_q[6:0], req_i.sda_in};
              enter_ph = PH_RBIT_LOW;
            end
            PH_RBIT_LOW: begin
              bit_d    = bit_q + 4'd1;
              enter_ph = (bit_d < BYTE_BITS) ? PH_RBIT_REL : PH_RACK_PREP;
            end
            PH_RACK_DONE: begin
              result_d   = {result_q[7:0], shift_q};
              byte_idx_d = byte_idx_q + 2'd1;
              if (func_q == FN_READ_WORD && byte_idx_d == 2'd1) begin
                shift_d  = '0;
                bit_d    = '0;
                enter_ph = PH_RBIT_REL;
              end else begin
                enter_ph = PH_STOP_SDA;
              end
            end
            PH_STOP_REL: begin
              enter   = 1'b0;
              phase_d = PH_IDLE;
              scl_d   = 1'b0;
              sda_d   = 1'b0;
              done    = 1'b1;
            end
            default: enter_ph = next_phase(phase_q);
          endcase
        end
      end
      default: begin
        phase_d = PH_IDLE;
        delay_d = '0;
        scl_d   = 1'b0;
        sda_d   = 1'b0;
      end
    endcase

    // phase entry: load the half period and set the line drives
    if (enter) begin
      phase_d = enter_ph;
      delay_d = hpt_load;
      case (enter_ph)
        PH_START_REL: begin
          scl_d = 1'b0;
          sda_d = 1'b0;
        end
        PH_START_SDA, PH_STOP_SDA: sda_d = 1'b1;
        PH_START_SCL, PH_WBIT_LOW, PH_WACK_LOW, PH_RBIT_LOW, PH_RACK_LOW: scl_d = 1'b1;
        PH_WBIT_SET: begin
          sda_d = ~shift_d[7];
          scl_d = 1'b0;
        end
        PH_WACK_REL, PH_RBIT_REL: begin
          sda_d = 1'b0;
          scl_d = 1'b0;
        end
        // ACK every read byte but the last
        PH_RACK_SET: begin
          sda_d = (func_d == FN_READ_WORD) && (byte_idx_d == 2'd0);
          scl_d = 1'b0;
        end
        PH_STOP_SCL: scl_d = 1'b0;
        PH_STOP_REL: sda_d = 1'b0;
        default: ;
      endcase
    end
  end

  always_comb begin
    res_o.scl_low   = scl_d;
    res_o.sda_low   = sda_d;
    res_o.busy_res  = (phase_d != PH_IDLE);
    res_o.done_res  = done;
    res_o.read_data = result_d;
    res_o.nak_seen  = nak_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hpt_q <= HPT_RESET;
    end else if (cfg_we_i) begin
      hpt_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_IDLE;
      delay_q    <= '0;
      bit_q      <= '0;
      shift_q    <= '0;
      byte_idx_q <= '0;
      result_q   <= '0;
      func_q     <= '0;
      dev_q      <= '0;
      reg_q      <= '0;
      data_q     <= '0;
      nak_q      <= 1'b0;
      scl_q      <= 1'b0;
      sda_q      <= 1'b0;
      restart_q  <= 1'b0;
    end else if (step_i) begin
      phase_q    <= phase_d;
      delay_q    <= delay_d;
      bit_q      <= bit_d;
      shift_q    <= shift_d;
      byte_idx_q <= byte_idx_d;
      result_q   <= result_d;
      func_q     <= func_d;
      dev_q      <= dev_d;
      reg_q      <= reg_d;
      data_q     <= data_d;
      nak_q      <= nak_d;
      scl_q      <= scl_d;
      sda_q      <= sda_d;
      restart_q  <= restart_d;
    end
  end

endmodule

/* design/i2crm_out_reg.sv */
// Result register of the I2C register master: holds one result beat and
// gives back-pressure to the input side. Depends on i2crm_pkg.
`timescale 1ns / 1ps

module i2crm_out_reg import i2crm_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    load_i,
  input  result_t res_i,
  input  logic    ready_i,
  output logic    ready_o,
  output logic    valid_o,
  output result_t res_o
);

  logic    valid_q, valid_d;
  result_t res_q;

  // free slot, or the held beat leaves this cycle
  assign ready_o = !valid_q || ready_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule

/* design/i2c_register_master.sv */
// Top level of the I2C register master: sequencer plus result register.
// Depends on i2crm_pkg, i2crm_in_if, i2crm_out_if, i2crm_core, i2crm_out_reg.
//
//   channel   dir   handshake          beat
//   in_i      in    valid/ready        go, func, addresses, data, scl_in, sda_in
//   out_o     out   valid/ready        scl_low, sda_low, busy, done, read_data, nak
//   cfg       in    cfg_we_i           half_period_ticks (16 bits)
//
// One input beat per clock; its result beat is shown the cycle after.
// The result register lets a new beat in while the held one is taken.
// If the result beat is not taken, the input is held off until it is.
// Reset (async, active low) gives idle phase, released lines, half period 300.
`timescale 1ns / 1ps

module i2c_register_master import i2crm_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  i2crm_in_if.sink    in_i,
  i2crm_out_if.source out_o
);

  logic    in_ready;
  logic    step;
  req_t    req;
  result_t res_next;
  result_t res_held;

  assign in_i.ready = in_ready;
  assign step       = in_i.valid && in_ready;

  always_comb begin
    req.go          = in_i.go;
    req.func        = in_i.func;
    req.device_addr = in_i.device_addr;
    req.reg_addr    = in_i.reg_addr;
    req.write_data  = in_i.write_data;
    req.scl_in      = in_i.scl_in;
    req.sda_in      = in_i.sda_in;
  end

  i2crm_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .step_i      (step),
    .req_i       (req),
    .res_o       (res_next)
  );

  i2crm_out_reg u_out_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (step),
    .res_i   (res_next),
    .ready_i (out_o.ready),
    .ready_o (in_ready),
    .valid_o (out_o.valid),
    .res_o   (res_held)
  );

  assign out_o.scl_low   = res_held.scl_low;
  assign out_o.sda_low   = res_held.sda_low;
  assign out_o.busy_res  = res_held.busy_res;
  assign out_o.done_res  = res_held.done_res;
  assign out_o.read_data = res_held.read_data;
  assign out_o.nak_seen  = res_held.nak_seen;

  a_accept_gives_beat: assert property (
    @(posedge clk_i) disable iff (!rst_ni) step |=> out_o.valid
  ) else $error("accepted beat produced no result beat");

  a_done_not_busy: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
      (out_o.valid && out_o.done_res) |-> !out_o.busy_res
  ) else $error("done pulse while still busy");

  a_done_lines_free: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
      (out_o.valid && out_o.done_res) |-> (!out_o.scl_low && !out_o.sda_low)
  ) else $error("bus lines still driven at transaction end");

endmodule
